// ===== src/ppmfd_pkg.sv =====
// Package for the PPM frame decoder: shared constants, register indexes
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package ppmfd_pkg;

  localparam int CHANNEL_COUNT_DEF = 8;
  localparam int MAX_EMIT          = 8;

  localparam int TS_W    = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_A_W = 2;
  localparam int OUT_W   = 40;

  localparam logic [CFG_A_W-1:0] REG_SYNC_GAP_MIN    = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_PULSE_WIDTH_MIN = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_PULSE_WIDTH_MAX = 2'd2;

  localparam logic [CFG_W-1:0] SYNC_GAP_MIN_RST    = 16'd2100;
  localparam logic [CFG_W-1:0] PULSE_WIDTH_MIN_RST = 16'd950;
  localparam logic [CFG_W-1:0] PULSE_WIDTH_MAX_RST = 16'd2050;

  localparam logic [TS_W-1:0] STICK_LO   = 16'd900;
  localparam logic [TS_W-1:0] STICK_HI   = 16'd2100;
  localparam logic [TS_W-1:0] DEAD_LO    = 16'd1450;
  localparam logic [TS_W-1:0] DEAD_HI    = 16'd1550;
  localparam logic [TS_W-1:0] SW_LOW_LO  = 16'd950;
  localparam logic [TS_W-1:0] SW_LOW_HI  = 16'd1050;
  localparam logic [TS_W-1:0] SW_HIGH_LO = 16'd1950;
  localparam logic [TS_W-1:0] SW_HIGH_HI = 16'd2050;
  localparam logic signed [16:0] STICK_CENTER = 17'sd1500;

  // floor(a * 4096 / 125) == (a * STICK_K) >> STICK_SH for a below 600.
  localparam logic [22:0] STICK_K  = 23'd4294968;
  localparam int          STICK_SH = 17;

  localparam logic [1:0] SW_INVALID = 2'd0;
  localparam logic [1:0] SW_LOW     = 2'd1;
  localparam logic [1:0] SW_MID     = 2'd2;
  localparam logic [1:0] SW_HIGH    = 2'd3;

  typedef struct packed {
    logic edge_accept;
    logic emit_clear;
    logic emit_next;
    logic rd_en;
    logic mul_en;
    logic out_load;
  } ppmfd_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic out_taken;
    logic emit_last;
  } ppmfd_status_t;

endpackage

`default_nettype wire

// ===== src/ppmfd_ctrl.sv =====
// Controller of the PPM frame decoder: takes edges and sequences the
// read, multiply, load and handshake steps of each channel result.
// Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire ppmfd_pkg::ppmfd_status_t st,
  output ppmfd_pkg::ppmfd_cmd_t         cmd
);
  import ppmfd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_LOAD,
    S_WAIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.edge_accept = 1'b1;
          if (st.frame_done) begin
            cmd.emit_clear = 1'b1;
            state_nxt      = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        if (st.out_taken) begin
          if (st.emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

`default_nettype wire

// ===== src/ppmfd_dp.sv =====
// Datapath of the PPM frame decoder: configuration registers, interval
// tracking, the channel width store and the stick and switch mapping.
// Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_dp #(
  parameter int CHANNEL_COUNT = ppmfd_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [ppmfd_pkg::CFG_A_W-1:0]          cfg_index,
  input  wire logic [ppmfd_pkg::CFG_W-1:0]            cfg_wdata,
  input  wire logic [ppmfd_pkg::TS_W-1:0]             in_tdata,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [ppmfd_pkg::OUT_W-1:0]                 out_tdata,
  output logic                                        out_tlast,
  input  wire ppmfd_pkg::ppmfd_cmd_t                  cmd,
  output ppmfd_pkg::ppmfd_status_t                    st
);
  import ppmfd_pkg::*;

  localparam int EMIT_N = (CHANNEL_COUNT < MAX_EMIT) ? CHANNEL_COUNT : MAX_EMIT;
  localparam int IDX_W  = (EMIT_N > 1) ? $clog2(EMIT_N) : 1;
  localparam int MEM_D  = 1 << IDX_W;
  localparam int CNT_W  = $clog2(CHANNEL_COUNT + 1);

  logic [CFG_W-1:0] sync_gap_min_r;
  logic [CFG_W-1:0] pulse_min_r;
  logic [CFG_W-1:0] pulse_max_r;

  logic [TS_W-1:0]  prev_ts_r;
  logic             armed_r;
  logic [CNT_W-1:0] count_r;
  logic [TS_W-1:0]  width_mem [MEM_D];

  logic [IDX_W-1:0] emit_idx_r;
  logic [TS_W-1:0]  width_r;
  logic [32:0]      prod_r;
  logic             stick_zero_r;
  logic             neg_r;

  logic             out_valid_r;
  logic [2:0]       out_ch_r;
  logic [TS_W-1:0]  out_width_r;
  logic [15:0]      out_stick_r;
  logic [1:0]       out_sw_r;
  logic             out_last_r;

  logic [TS_W-1:0]  delta;
  logic             is_sync;
  logic             in_win;
  logic             store;

  assign delta   = in_tdata - prev_ts_r;
  assign is_sync = (delta >= sync_gap_min_r);
  assign in_win  = (delta >= pulse_min_r) && (delta <= pulse_max_r);
  assign store   = !is_sync && armed_r && in_win;

  assign st.frame_done = store && (count_r == CNT_W'(CHANNEL_COUNT - 1));
  assign st.out_taken  = out_valid_r && out_tready;
  assign st.emit_last  = (emit_idx_r == IDX_W'(EMIT_N - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_gap_min_r <= SYNC_GAP_MIN_RST;
      pulse_min_r    <= PULSE_WIDTH_MIN_RST;
      pulse_max_r    <= PULSE_WIDTH_MAX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SYNC_GAP_MIN:    sync_gap_min_r <= cfg_wdata;
        REG_PULSE_WIDTH_MIN: pulse_min_r    <= cfg_wdata;
        REG_PULSE_WIDTH_MAX: pulse_max_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ts_r <= '0;
      armed_r   <= 1'b0;
      count_r   <= '0;
    end else if (cmd.edge_accept) begin
      prev_ts_r <= in_tdata;
      if (is_sync) begin
        armed_r <= 1'b1;
        count_r <= '0;
      end else if (armed_r && !in_win) begin
        armed_r <= 1'b0;
      end else if (store) begin
        if (st.frame_done) begin
          armed_r <= 1'b0;
          count_r <= '0;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_accept && store && (count_r < CNT_W'(EMIT_N))) begin
      width_mem[count_r[IDX_W-1:0]] <= delta;
    end
    if (cmd.rd_en) begin
      width_r <= width_mem[emit_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_clear) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_next) begin
      emit_idx_r <= emit_idx_r + 1'b1;
    end
  end

  logic [2:0]         ch3;
  logic signed [16:0] dev;
  logic signed [16:0] dev_abs;
  logic [9:0]         dev_mag;
  logic               inv_ch;

  assign ch3     = 3'(emit_idx_r);
  assign dev     = $signed({1'b0, width_r}) - STICK_CENTER;
  assign dev_abs = dev[16] ? -dev : dev;
  assign dev_mag = dev_abs[9:0];
  assign inv_ch  = (ch3 == 3'd0) || (ch3 == 3'd3);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r       <= 33'(dev_mag) * 33'(STICK_K);
      stick_zero_r <= ((width_r > DEAD_LO) && (width_r < DEAD_HI)) ||
                      !((width_r > STICK_LO) && (width_r < STICK_HI));
      neg_r        <= dev[16] ^ inv_ch;
    end
  end

  logic [14:0]        stick_q;
  logic signed [15:0] stick_val;
  logic [1:0]         sw_code;
  logic               three_pos;
  logic               sw_low;
  logic               sw_mid;
  logic               sw_high;

  assign stick_q   = prod_r[STICK_SH+14:STICK_SH];
  assign three_pos = (ch3 == 3'd5) || (ch3 == 3'd6);
  assign sw_low    = (width_r > SW_LOW_LO) && (width_r < SW_LOW_HI);
  assign sw_mid    = (width_r > DEAD_LO) && (width_r < DEAD_HI);
  assign sw_high   = (width_r > SW_HIGH_LO) && (width_r < SW_HIGH_HI);

  always_comb begin
    if (stick_zero_r) begin
      stick_val = '0;
    end else if (neg_r) begin
      stick_val = -$signed({1'b0, stick_q});
    end else begin
      stick_val = $signed({1'b0, stick_q});
    end
  end

  always_comb begin
    priority if (sw_low) begin
      sw_code = SW_LOW;
    end else if (three_pos && sw_mid) begin
      sw_code = SW_MID;
    end else if (sw_high) begin
      sw_code = three_pos ? SW_HIGH : SW_MID;
    end else begin
      sw_code = SW_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (st.out_taken) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch_r    <= ch3;
      out_width_r <= width_r;
      out_stick_r <= (ch3 < 3'd4) ? stick_val : 16'sd0;
      out_sw_r    <= (ch3 < 3'd4) ? SW_INVALID : sw_code;
      out_last_r  <= st.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_sw_r, out_stick_r, out_width_r, out_ch_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(CHANNEL_COUNT))
    else $error("channel count reached the frame length");

  a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.edge_accept && st.frame_done |=> !armed_r && (count_r == '0))
    else $error("frame not closed after its last pulse");

  a_sync_arms: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.edge_accept && is_sync |=> armed_r && (count_r == '0))
    else $error("sync gap did not arm the frame");

  a_no_edge_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !cmd.edge_accept)
    else $error("edge taken while a result is pending");

endmodule

`default_nettype wire

// ===== src/ppm_frame_decoder_stick_map.sv =====
// PPM frame decoder with stick and switch mapping. An edge is accepted
// whenever the controller is idle. The edge that completes a frame
// starts the emission of min(CHANNEL_COUNT, 8) results, each taking the
// steps width store read, multiply for the stick scaling, output load and
// handshake, so a frame end holds the input while the results drain.
// Configuration writes are registered.
// Depends on ppmfd_pkg, ppmfd_ctrl and ppmfd_dp.
`default_nettype none

module ppm_frame_decoder_stick_map #(
  parameter int CHANNEL_COUNT = ppmfd_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ppmfd_pkg::CFG_A_W-1:0] cfg_index,
  input  wire logic [ppmfd_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [15:0] edge_timestamp
  input  wire logic [ppmfd_pkg::TS_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [2:0] channel_index, [18:3] pulse_width, [34:19] stick_value,
  // [36:35] switch_position, [39:37] zero
  output logic [ppmfd_pkg::OUT_W-1:0]        out_tdata,
  output logic                               out_tlast
);
  import ppmfd_pkg::*;

  ppmfd_cmd_t    cmd;
  ppmfd_status_t st;

  ppmfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ppmfd_dp #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

`default_nettype wire

// ===== tb/sv/ppm_frame_decoder_stick_map_tb.sv =====
// Self-checking testbench for ppm_frame_decoder_stick_map: drives PPM edge timestamps,
// predicts every channel result in-bench and checks each result in order of arrival.
// Depends on ppmfd_pkg and the ppm_frame_decoder_stick_map RTL.
`default_nettype none

module ppm_frame_decoder_stick_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppmfd_pkg::*;

  typedef struct {
    logic [2:0]  channel;
    logic [15:0] width;
    logic [15:0] stick;
    logic [1:0]  switch_pos;
    logic        last;
  } channel_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_A_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [TS_W-1:0]     in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tlast;

  // Predictor state and its copy of the registers.
  logic [15:0] last_stamp = '0;
  logic        frame_open = 1'b0;
  int          pulses_seen = 0;
  logic [15:0] pulse_widths [8];
  logic [15:0] sync_min = SYNC_GAP_MIN_RST;
  logic [15:0] width_min = PULSE_WIDTH_MIN_RST;
  logic [15:0] width_max = PULSE_WIDTH_MAX_RST;

  channel_result_t pending_channels[$];
  int              error_count = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int              hold_off = 0;

  int unsigned edge_widths [22] = '{900, 901, 949, 950, 951, 1049, 1050, 1449, 1450, 1451,
                                    1500, 1549, 1550, 1551, 1949, 1950, 1951, 2049, 2050,
                                    2051, 2099, 2100};

  ppm_frame_decoder_stick_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] stick_of(int k, logic [15:0] w);
    int v;
    if (w > 1450 && w < 1550) return 16'd0;
    if (!(w > 900 && w < 2100)) return 16'd0;
    v = ((int'(w) - 1500) * 16384) / 500;
    if (k == 0 || k == 3) v = -v;
    return v[15:0];
  endfunction

  function automatic logic [1:0] switch_of(int k, logic [15:0] w);
    if (w > 950 && w < 1050) return SW_LOW;
    if (k == 5 || k == 6) begin
      if (w > 1450 && w < 1550) return SW_MID;
      if (w > 1950 && w < 2050) return SW_HIGH;
      return SW_INVALID;
    end
    if (w > 1950 && w < 2050) return SW_MID;
    return SW_INVALID;
  endfunction

  function automatic void decode_edge(logic [15:0] stamp);
    logic [15:0]     interval;
    channel_result_t r;
    interval = stamp - last_stamp;
    last_stamp = stamp;
    if (interval >= sync_min) begin
      frame_open = 1'b1;
      pulses_seen = 0;
      return;
    end
    if (!frame_open) return;
    if (interval < width_min || interval > width_max) begin
      frame_open = 1'b0;
      return;
    end
    pulse_widths[pulses_seen] = interval;
    pulses_seen++;
    if (pulses_seen < 8) return;
    frame_open = 1'b0;
    pulses_seen = 0;
    for (int k = 0; k < 8; k++) begin
      r.channel    = k[2:0];
      r.width      = pulse_widths[k];
      r.stick      = (k < 4) ? stick_of(k, pulse_widths[k]) : 16'd0;
      r.switch_pos = (k < 4) ? SW_INVALID : switch_of(k, pulse_widths[k]);
      r.last       = (k == 7);
      pending_channels.push_back(r);
    end
  endfunction

  task automatic send_stamp(input logic [15:0] stamp);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    decode_edge(stamp);
  endtask

  task automatic send_interval(input int interval);
    send_stamp(last_stamp + interval[15:0]);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_channels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] sync_gap, input logic [15:0] lo,
                            input logic [15:0] hi);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SYNC_GAP_MIN;
    cfg_wdata <= sync_gap;
    @(posedge clk);
    cfg_index <= REG_PULSE_WIDTH_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_PULSE_WIDTH_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sync_min  = sync_gap;
    width_min = lo;
    width_max = hi;
  endtask

  function automatic int pick_pulse(int lo, int hi);
    int c;
    c = edge_widths[$urandom_range(21)];
    if ($urandom_range(2) == 0 && c >= lo && c <= hi) return c;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int pick_sync();
    int top;
    if ($urandom_range(15) == 0) return 65535;
    top = int'(sync_min) + 3000;
    if (top > 65535) top = 65535;
    return $urandom_range(top, int'(sync_min));
  endfunction

  task automatic test_default_frames();
    send_stamp(16'hFFFF);
    send_interval(950);
    send_interval(2050);
    send_interval(1451);
    send_interval(1550);
    send_interval(1000);
    send_interval(1500);
    send_interval(2000);
    send_interval(2049);
    send_interval(2100);
    send_interval(1200);
    send_interval(1449);
    send_interval(1800);
    send_interval(3000);
    send_interval(2051);
    send_interval(1000);
    send_interval(0);
    send_stamp(16'h0000);
  endtask

  task automatic test_open_window();
    set_config(16'hFFFF, 16'h0000, 16'hFFFF);
    send_interval(65535);
    send_interval(901);
    send_interval(2099);
    send_interval(900);
    send_interval(2100);
    send_interval(0);
    send_interval(1449);
    send_interval(949);
    send_interval(65534);
  endtask

  task automatic test_inverted_window();
    set_config(16'd2100, 16'hFFFF, 16'h0000);
    send_interval(5000);
    send_interval(1500);
    send_interval(1000);
  endtask

  task automatic test_zero_sync();
    set_config(16'h0000, 16'd950, 16'd2050);
    send_interval(1500);
    send_interval(0);
  endtask

  task automatic test_random_phase(input int count);
    int sent, kind, hi, n;
    sent = 0;
    hi = (width_max < sync_min) ? int'(width_max) : int'(sync_min) - 1;
    while (sent < count) begin
      kind = $urandom_range(9);
      if (kind == 9) begin
        repeat (3) send_stamp(16'($urandom_range(65535)));
        sent += 3;
      end else begin
        send_interval(pick_sync());
        n = (kind <= 6) ? 8 : $urandom_range(7);
        for (int i = 0; i < n; i++) send_interval(pick_pulse(int'(width_min), hi));
        sent += n + 1;
        if (kind == 7) begin
          send_interval($urandom_range(int'(width_min) - 1));
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_config(SYNC_GAP_MIN_RST, PULSE_WIDTH_MIN_RST, PULSE_WIDTH_MAX_RST);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off = 400;
    repeat (3) begin
      send_interval(pick_sync());
      repeat (8) send_interval(pick_pulse(950, 2050));
    end
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off = hold_off - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    channel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_channels.size() == 0) begin
        $error("unexpected result: channel_index %0d, pulse_width %0d",
               out_tdata[2:0], out_tdata[18:3]);
        error_count++;
      end else begin
        want = pending_channels.pop_front();
        if (out_tdata[2:0] !== want.channel) begin
          $error("channel_index: expected %0d, got %0d", want.channel, out_tdata[2:0]);
          error_count++;
        end
        if (out_tdata[18:3] !== want.width) begin
          $error("pulse_width: expected %0d, got %0d", want.width, out_tdata[18:3]);
          error_count++;
        end
        if (out_tdata[34:19] !== want.stick) begin
          $error("stick_value: expected %0d, got %0d", $signed(want.stick),
                 $signed(out_tdata[34:19]));
          error_count++;
        end
        if (out_tdata[36:35] !== want.switch_pos) begin
          $error("switch_position: expected %0d, got %0d", want.switch_pos,
                 out_tdata[36:35]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("frame_last: expected %0d, got %0d", want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    test_default_frames();
    test_open_window();
    test_inverted_window();
    test_zero_sync();
    set_config(SYNC_GAP_MIN_RST, PULSE_WIDTH_MIN_RST, PULSE_WIDTH_MAX_RST);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_phase(80);
    set_config(16'd5000, 16'd800, 16'd2200);
    send_idle_pct  = 62;
    recv_stall_pct = 0;
    test_random_phase(80);
    set_config(16'd1800, 16'd950, 16'd2050);
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    test_random_phase(80);
    set_config(16'd3000, 16'd880, 16'd2120);
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    test_random_phase(80);
    test_backpressure();
    in_tvalid <= 1'b0;
    while (pending_channels.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (pending_channels.size() != 0) begin
      $error("%0d expected results never arrived", pending_channels.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/ppmfd_pkg.sv
src/ppmfd_ctrl.sv
src/ppmfd_dp.sv
src/ppm_frame_decoder_stick_map.sv
tb/sv/ppm_frame_decoder_stick_map_tb.sv
